>>> rtl/kvl_pkg.sv
// Shared types and constants for the key/value config lexer.
// Depends on nothing; used by every module of the block.
`default_nettype none

package kvl_pkg;

   localparam logic [7:0] MAX_TOKEN_LEN = 8'd255;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQUOT = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SQUOT = 8'h27;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQUAL = 8'h3D;

   typedef enum logic [1:0] {
      MODE_BLANK   = 2'd0,
      MODE_COMMENT = 2'd1,
      MODE_WORD    = 2'd2,
      MODE_STRING  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_WORD   = 3'd0,
      KIND_STRING = 3'd1,
      KIND_EQUAL  = 3'd2,
      KIND_SEMI   = 3'd3,
      KIND_END    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ORDER    = 2'd1,
      ST_UNTERM   = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       has_char;
      logic [7:0] ch;
      logic       token_done;
      logic [1:0] status;
      logic       last;
   } result_type;

   // one queue word: all results caused by one input byte
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } entry_type;

endpackage

`default_nettype wire

>>> rtl/kvl_front.sv
// Front end: accepts text bytes, runs the mode machine and order checker,
// and pushes the results of each byte as one word. Depends on kvl_pkg.
`default_nettype none

module kvl_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_in_char,
   input  wire logic               q_full,
   output logic                    q_push,
   output kvl_pkg::entry_type      q_word
);

   kvl_pkg::mode_type   mode_ff, mode_in;
   logic                quote_ff, quote_in;
   logic [1:0]          pos_ff, pos_in;
   logic [7:0]          len_ff, len_in;
   kvl_pkg::status_type err_ff, err_in;

   kvl_pkg::result_type res [2];
   logic [1:0]          cnt;
   logic                do_blank, do_chk, chk_ok, addb, fin, is_sep;
   kvl_pkg::kind_type   chk_kind, add_kind;
   kvl_pkg::result_type tmp;
   logic                accept;
   logic [7:0]          c;

   assign c         = req_in_char;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_sep    = (c == kvl_pkg::CH_SPACE) || (c == kvl_pkg::CH_TAB) ||
                      (c == kvl_pkg::CH_CR) || (c == kvl_pkg::CH_LF);

   always_comb begin
      mode_in  = mode_ff;
      quote_in = quote_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      err_in   = err_ff;
      res[0]   = '0;
      res[1]   = '0;
      cnt      = 2'd0;
      do_blank = 1'b0;
      do_chk   = 1'b0;
      chk_ok   = 1'b0;
      chk_kind = kvl_pkg::KIND_WORD;
      addb     = 1'b0;
      add_kind = kvl_pkg::KIND_WORD;
      fin      = 1'b0;
      tmp      = '0;

      case (mode_ff)
         kvl_pkg::MODE_BLANK: begin
            do_blank = 1'b1;
         end
         kvl_pkg::MODE_COMMENT: begin
            if (c == kvl_pkg::CH_NUL) begin
               fin = 1'b1;
            end else if (c == kvl_pkg::CH_LF) begin
               mode_in = kvl_pkg::MODE_BLANK;
            end
         end
         kvl_pkg::MODE_WORD: begin
            if (is_sep || c == kvl_pkg::CH_EQUAL || c == kvl_pkg::CH_SEMI ||
                c == kvl_pkg::CH_NUL) begin
               if (err_in == kvl_pkg::ST_OK) begin
                  tmp            = '0;
                  tmp.kind       = kvl_pkg::KIND_WORD;
                  tmp.token_done = 1'b1;
                  res[cnt[0]]    = tmp;
                  cnt            = cnt + 2'd1;
               end
               len_in   = '0;
               mode_in  = kvl_pkg::MODE_BLANK;
               do_blank = 1'b1;
            end else begin
               addb     = 1'b1;
               add_kind = kvl_pkg::KIND_WORD;
            end
         end
         default: begin
            if (c == kvl_pkg::CH_NUL) begin
               fin = 1'b1;
            end else if ((!quote_ff && c == kvl_pkg::CH_DQUOT) ||
                         (quote_ff && c == kvl_pkg::CH_SQUOT)) begin
               if (err_in == kvl_pkg::ST_OK) begin
                  tmp            = '0;
                  tmp.kind       = kvl_pkg::KIND_STRING;
                  tmp.token_done = 1'b1;
                  res[cnt[0]]    = tmp;
                  cnt            = cnt + 2'd1;
               end
               len_in  = '0;
               mode_in = kvl_pkg::MODE_BLANK;
            end else begin
               addb     = 1'b1;
               add_kind = kvl_pkg::KIND_STRING;
            end
         end
      endcase

      if (do_blank) begin
         if (c == kvl_pkg::CH_NUL) begin
            mode_in = kvl_pkg::MODE_BLANK;
            fin     = 1'b1;
         end else if (c == kvl_pkg::CH_HASH) begin
            mode_in = kvl_pkg::MODE_COMMENT;
         end else if (is_sep) begin
            mode_in = kvl_pkg::MODE_BLANK;
         end else if (c == kvl_pkg::CH_EQUAL || c == kvl_pkg::CH_SEMI) begin
            mode_in  = kvl_pkg::MODE_BLANK;
            do_chk   = 1'b1;
            chk_kind = (c == kvl_pkg::CH_EQUAL) ? kvl_pkg::KIND_EQUAL
                                                : kvl_pkg::KIND_SEMI;
         end else if (c == kvl_pkg::CH_DQUOT || c == kvl_pkg::CH_SQUOT) begin
            quote_in = (c == kvl_pkg::CH_SQUOT);
            mode_in  = kvl_pkg::MODE_STRING;
            len_in   = '0;
            do_chk   = 1'b1;
            chk_kind = kvl_pkg::KIND_STRING;
         end else begin
            mode_in  = kvl_pkg::MODE_WORD;
            len_in   = '0;
            do_chk   = 1'b1;
            chk_kind = kvl_pkg::KIND_WORD;
            addb     = 1'b1;
            add_kind = kvl_pkg::KIND_WORD;
         end
      end

      // statement order check
      if (do_chk && err_in == kvl_pkg::ST_OK) begin
         case (pos_ff)
            2'd0:    chk_ok = (chk_kind == kvl_pkg::KIND_WORD);
            2'd1:    chk_ok = (chk_kind == kvl_pkg::KIND_EQUAL);
            2'd2:    chk_ok = (chk_kind inside {kvl_pkg::KIND_WORD,
                                                kvl_pkg::KIND_STRING});
            default: chk_ok = (chk_kind == kvl_pkg::KIND_SEMI);
         endcase
         if (!chk_ok) begin
            err_in = kvl_pkg::ST_ORDER;
         end else begin
            pos_in = pos_ff + 2'd1;
            if (chk_kind == kvl_pkg::KIND_EQUAL || chk_kind == kvl_pkg::KIND_SEMI) begin
               tmp         = '0;
               tmp.kind    = chk_kind;
               res[cnt[0]] = tmp;
               cnt         = cnt + 2'd1;
            end
         end
      end

      if (addb && err_in == kvl_pkg::ST_OK) begin
         if (len_in >= kvl_pkg::MAX_TOKEN_LEN) begin
            err_in = kvl_pkg::ST_TOO_LONG;
         end else begin
            len_in       = len_in + 8'd1;
            tmp          = '0;
            tmp.kind     = add_kind;
            tmp.has_char = 1'b1;
            tmp.ch       = c;
            res[cnt[0]]  = tmp;
            cnt          = cnt + 2'd1;
         end
      end

      if (fin) begin
         tmp      = '0;
         tmp.kind = kvl_pkg::KIND_END;
         if (err_in != kvl_pkg::ST_OK) begin
            tmp.status = err_in;
         end else if (mode_in == kvl_pkg::MODE_STRING) begin
            tmp.status = kvl_pkg::ST_UNTERM;
         end else if (pos_in != 2'd0) begin
            tmp.status = kvl_pkg::ST_ORDER;
         end
         res[cnt[0]] = tmp;
         cnt         = cnt + 2'd1;
         mode_in     = kvl_pkg::MODE_BLANK;
         quote_in    = 1'b0;
         pos_in      = '0;
         len_in      = '0;
         err_in      = kvl_pkg::ST_OK;
      end

      if (cnt == 2'd2) begin
         res[1].last = 1'b1;
      end else begin
         res[0].last = 1'b1;
      end
   end

   assign q_push = accept && (cnt != 2'd0);
   assign q_word = {cnt == 2'd2, res[0], res[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= kvl_pkg::MODE_BLANK;
         quote_ff <= 1'b0;
         pos_ff   <= '0;
         len_ff   <= '0;
         err_ff   <= kvl_pkg::ST_OK;
      end else if (accept) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/kvl_fifo.sv
// Short queue of result words between the front and back ends.
// Depends on kvl_pkg.
`default_nettype none

module kvl_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire kvl_pkg::entry_type  wr_word,
   input  wire logic                pop,
   output kvl_pkg::entry_type       rd_word,
   output logic                     full,
   output logic                     empty
);

   kvl_pkg::entry_type                  mem_ff [kvl_pkg::FIFO_DEPTH];
   logic [kvl_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [kvl_pkg::FIFO_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                                do_push, do_pop;

   assign full    = (cnt_ff == kvl_pkg::FIFO_CNT_W'(kvl_pkg::FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_word = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + kvl_pkg::FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - kvl_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + kvl_pkg::FIFO_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + kvl_pkg::FIFO_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

`default_nettype wire

>>> rtl/kvl_back.sv
// Back end: pops queue words and drives results one per cycle, while
// rsp_ready is high, through a registered output, holding a second
// result when a word carries two. Depends on kvl_pkg.
`default_nettype none

module kvl_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire kvl_pkg::entry_type  q_word,
   input  wire logic                q_empty,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_out_kind,
   output logic                     rsp_has_char,
   output logic [7:0]               rsp_out_char,
   output logic                     rsp_token_done,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last_of_run
);

   kvl_pkg::result_type out_ff, sec_ff;
   logic                valid_ff, sec_valid_ff;
   logic                load;

   assign load  = !valid_ff || rsp_ready;
   assign q_pop = load && !sec_valid_ff && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else if (load) begin
         if (sec_valid_ff) begin
            valid_ff     <= 1'b1;
            sec_valid_ff <= 1'b0;
         end else if (!q_empty) begin
            valid_ff     <= 1'b1;
            sec_valid_ff <= q_word.two;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (sec_valid_ff) begin
            out_ff <= sec_ff;
         end else if (!q_empty) begin
            out_ff <= q_word.r0;
            sec_ff <= q_word.r1;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_kind    = out_ff.kind;
   assign rsp_has_char    = out_ff.has_char;
   assign rsp_out_char    = out_ff.ch;
   assign rsp_token_done  = out_ff.token_done;
   assign rsp_status      = out_ff.status;
   assign rsp_last_of_run = out_ff.last;

endmodule

`default_nettype wire

>>> rtl/key_value_config_lexer.sv
// Key/value config lexer top level: front end, result queue, back end.
// Depends on kvl_pkg, kvl_front, kvl_fifo and kvl_back.
//
// One text byte is accepted per cycle while the four-word result queue
// has room. Results leave one per cycle while rsp_ready is high; for a
// byte that yields two (token close plus '=', ';' or end) the back end
// holds the second until the first is taken. Results pass through the
// queue and the back end's output register before they are offered.
// A zero byte ends the text, emits the status and restarts the lexer,
// so texts may follow back to back.
`default_nettype none

module key_value_config_lexer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_char,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_out_kind,
   output logic             rsp_has_char,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_token_done,
   output logic [1:0]       rsp_status,
   output logic             rsp_last_of_run
);

   kvl_pkg::entry_type push_word, pop_word;
   logic               q_push, q_pop, q_full, q_empty;

   kvl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_char (req_in_char),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_word      (push_word)
   );

   kvl_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_word (push_word),
      .pop     (q_pop),
      .rd_word (pop_word),
      .full    (q_full),
      .empty   (q_empty)
   );

   kvl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_word          (pop_word),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_has_char    (rsp_has_char),
      .rsp_out_char    (rsp_out_char),
      .rsp_token_done  (rsp_token_done),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

>>> rtl/kvl_checker.sv
// Port-level checks on the lexer result channel, bound to the top level.
// Depends on kvl_pkg and key_value_config_lexer.
`default_nettype none

module kvl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_out_kind,
   input wire logic       rsp_has_char,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_token_done,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_last_of_run
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind) &&
      $stable(rsp_out_char) && $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   a_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_char |-> !rsp_token_done &&
      (rsp_out_kind == kvl_pkg::KIND_WORD || rsp_out_kind == kvl_pkg::KIND_STRING))
      else $error("content byte on wrong kind");

   a_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_done |-> !rsp_has_char &&
      (rsp_out_kind == kvl_pkg::KIND_WORD || rsp_out_kind == kvl_pkg::KIND_STRING))
      else $error("bad token close");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != kvl_pkg::KIND_END |-> rsp_status == kvl_pkg::ST_OK)
      else $error("status outside end result");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == kvl_pkg::KIND_END |-> rsp_last_of_run)
      else $error("end result not last of run");

endmodule

bind key_value_config_lexer kvl_checker u_kvl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_kind    (rsp_out_kind),
   .rsp_has_char    (rsp_has_char),
   .rsp_out_char    (rsp_out_char),
   .rsp_token_done  (rsp_token_done),
   .rsp_status      (rsp_status),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire

>>> bench/key_value_config_lexer_test.sv
// Self-checking bench for key_value_config_lexer: directed table, then random config texts.
// Uses a behavioral lexer predictor and a queue of expected result words.
// Depends on kvl_pkg and the key_value_config_lexer RTL.
`timescale 1ns / 100ps

module key_value_config_lexer_test;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_TARGET = 650;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 150;

   localparam kvl_pkg::result_type NO_RES = '0;
   localparam logic [7:0] SPECIAL_CHARS [10] = '{
      kvl_pkg::CH_SPACE, kvl_pkg::CH_TAB, kvl_pkg::CH_CR, kvl_pkg::CH_LF, kvl_pkg::CH_EQUAL,
      kvl_pkg::CH_SEMI, kvl_pkg::CH_HASH, kvl_pkg::CH_DQUOT, kvl_pkg::CH_SQUOT, 8'h0B};

   typedef struct packed {
      logic [7:0]          ch;
      logic [1:0]          n_typed;
      kvl_pkg::result_type r0;
      kvl_pkg::result_type r1;
   } step_row_type;

   // n_typed = 0: results come from the predictor
   localparam step_row_type DIRECTED_STEPS [26] = '{
      '{8'h6B, 2'd1,
        '{kvl_pkg::KIND_WORD, 1'b1, 8'h6B, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_EQUAL, 2'd2,
        '{kvl_pkg::KIND_WORD, 1'b0, 8'h00, 1'b1, kvl_pkg::ST_OK, 1'b0},
        '{kvl_pkg::KIND_EQUAL, 1'b0, 8'h00, 1'b0, kvl_pkg::ST_OK, 1'b1}},
      '{kvl_pkg::CH_SQUOT, 2'd0, NO_RES, NO_RES},
      '{8'hFF, 2'd1,
        '{kvl_pkg::KIND_STRING, 1'b1, 8'hFF, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_SQUOT, 2'd1,
        '{kvl_pkg::KIND_STRING, 1'b0, 8'h00, 1'b1, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_SEMI, 2'd1,
        '{kvl_pkg::KIND_SEMI, 1'b0, 8'h00, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_NUL, 2'd1,
        '{kvl_pkg::KIND_END, 1'b0, 8'h00, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_EQUAL, 2'd0, NO_RES, NO_RES},
      '{8'h61, 2'd0, NO_RES, NO_RES},
      '{kvl_pkg::CH_NUL, 2'd1,
        '{kvl_pkg::KIND_END, 1'b0, 8'h00, 1'b0, kvl_pkg::ST_ORDER, 1'b1}, NO_RES},
      '{8'h0B, 2'd1,
        '{kvl_pkg::KIND_WORD, 1'b1, 8'h0B, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_HASH, 2'd1,
        '{kvl_pkg::KIND_WORD, 1'b1, 8'h23, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_TAB, 2'd1,
        '{kvl_pkg::KIND_WORD, 1'b0, 8'h00, 1'b1, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_CR, 2'd0, NO_RES, NO_RES},
      '{kvl_pkg::CH_EQUAL, 2'd1,
        '{kvl_pkg::KIND_EQUAL, 1'b0, 8'h00, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_DQUOT, 2'd0, NO_RES, NO_RES},
      '{8'h01, 2'd1,
        '{kvl_pkg::KIND_STRING, 1'b1, 8'h01, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_NUL, 2'd1,
        '{kvl_pkg::KIND_END, 1'b0, 8'h00, 1'b0, kvl_pkg::ST_UNTERM, 1'b1}, NO_RES},
      '{kvl_pkg::CH_HASH, 2'd0, NO_RES, NO_RES},
      '{kvl_pkg::CH_SEMI, 2'd0, NO_RES, NO_RES},
      '{kvl_pkg::CH_LF, 2'd0, NO_RES, NO_RES},
      '{8'h76, 2'd1,
        '{kvl_pkg::KIND_WORD, 1'b1, 8'h76, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_DQUOT, 2'd1,
        '{kvl_pkg::KIND_WORD, 1'b1, 8'h22, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES},
      '{kvl_pkg::CH_NUL, 2'd2,
        '{kvl_pkg::KIND_WORD, 1'b0, 8'h00, 1'b1, kvl_pkg::ST_OK, 1'b0},
        '{kvl_pkg::KIND_END, 1'b0, 8'h00, 1'b0, kvl_pkg::ST_ORDER, 1'b1}},
      '{kvl_pkg::CH_SPACE, 2'd0, NO_RES, NO_RES},
      '{kvl_pkg::CH_NUL, 2'd1,
        '{kvl_pkg::KIND_END, 1'b0, 8'h00, 1'b0, kvl_pkg::ST_OK, 1'b1}, NO_RES}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_char = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_out_kind;
   logic       rsp_has_char;
   logic [7:0] rsp_out_char;
   logic       rsp_token_done;
   logic [1:0] rsp_status;
   logic       rsp_last_of_run;

   key_value_config_lexer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_char     (req_in_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_has_char    (rsp_has_char),
      .rsp_out_char    (rsp_out_char),
      .rsp_token_done  (rsp_token_done),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #2 clock = ~clock;

   // lexer predictor state
   kvl_pkg::mode_type   lx_mode = kvl_pkg::MODE_BLANK;
   logic                in_single_quote = 1'b0;
   logic [1:0]          stmt_pos = 2'd0;
   logic [7:0]          tok_len = 8'd0;
   kvl_pkg::status_type lex_err = kvl_pkg::ST_OK;

   kvl_pkg::result_type step_results [$];
   kvl_pkg::result_type pending_tokens [$];
   logic [7:0]          text_q [$];

   int  error_count = 0;
   int  checked_count = 0;
   int  bytes_sent = 0;
   int  cycle_count = 0;
   int  hold_asked = 0;
   int  hold_given = 0;
   int  hold_left = 0;
   bit  calm = 1'b0;

   task automatic flag_error(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic bit separator(logic [7:0] c);
      return c == kvl_pkg::CH_SPACE || c == kvl_pkg::CH_TAB || c == kvl_pkg::CH_CR ||
             c == kvl_pkg::CH_LF;
   endfunction

   function automatic void emit(kvl_pkg::kind_type k, logic hc, logic [7:0] c, logic done,
                                kvl_pkg::status_type st);
      kvl_pkg::result_type r;
      r.kind = k;
      r.has_char = hc;
      r.ch = hc ? c : 8'h00;
      r.token_done = done;
      r.status = st;
      r.last = 1'b0;
      step_results.push_back(r);
   endfunction

   // statement order: key word, '=', word or string, ';'
   function automatic bit order_ok(kvl_pkg::kind_type k);
      bit ok;
      if (lex_err != kvl_pkg::ST_OK)
         return 1'b0;
      case (stmt_pos)
         2'd0:    ok = (k == kvl_pkg::KIND_WORD);
         2'd1:    ok = (k == kvl_pkg::KIND_EQUAL);
         2'd2:    ok = (k == kvl_pkg::KIND_WORD || k == kvl_pkg::KIND_STRING);
         default: ok = (k == kvl_pkg::KIND_SEMI);
      endcase
      if (!ok) begin
         lex_err = kvl_pkg::ST_ORDER;
         return 1'b0;
      end
      stmt_pos = stmt_pos + 2'd1;
      return 1'b1;
   endfunction

   function automatic void append_char(kvl_pkg::kind_type k, logic [7:0] c);
      if (lex_err != kvl_pkg::ST_OK)
         return;
      if (tok_len >= kvl_pkg::MAX_TOKEN_LEN) begin
         lex_err = kvl_pkg::ST_TOO_LONG;
         return;
      end
      tok_len++;
      emit(k, 1'b1, c, 1'b0, kvl_pkg::ST_OK);
   endfunction

   function automatic void close_text();
      kvl_pkg::status_type st;
      st = lex_err;
      if (st == kvl_pkg::ST_OK && lx_mode == kvl_pkg::MODE_STRING)
         st = kvl_pkg::ST_UNTERM;
      else if (st == kvl_pkg::ST_OK && stmt_pos != 2'd0)
         st = kvl_pkg::ST_ORDER;
      emit(kvl_pkg::KIND_END, 1'b0, 8'h00, 1'b0, st);
      lx_mode = kvl_pkg::MODE_BLANK;
      in_single_quote = 1'b0;
      stmt_pos = 2'd0;
      tok_len = 8'd0;
      lex_err = kvl_pkg::ST_OK;
   endfunction

   function automatic void blank_step(logic [7:0] c);
      kvl_pkg::kind_type k;
      if (c == kvl_pkg::CH_NUL) begin
         lx_mode = kvl_pkg::MODE_BLANK;
         close_text();
      end else if (c == kvl_pkg::CH_HASH) begin
         lx_mode = kvl_pkg::MODE_COMMENT;
      end else if (separator(c)) begin
         lx_mode = kvl_pkg::MODE_BLANK;
      end else if (c == kvl_pkg::CH_EQUAL || c == kvl_pkg::CH_SEMI) begin
         k = (c == kvl_pkg::CH_EQUAL) ? kvl_pkg::KIND_EQUAL : kvl_pkg::KIND_SEMI;
         lx_mode = kvl_pkg::MODE_BLANK;
         if (order_ok(k))
            emit(k, 1'b0, 8'h00, 1'b0, kvl_pkg::ST_OK);
      end else if (c == kvl_pkg::CH_DQUOT || c == kvl_pkg::CH_SQUOT) begin
         in_single_quote = (c == kvl_pkg::CH_SQUOT);
         lx_mode = kvl_pkg::MODE_STRING;
         tok_len = 8'd0;
         void'(order_ok(kvl_pkg::KIND_STRING));
      end else begin
         lx_mode = kvl_pkg::MODE_WORD;
         tok_len = 8'd0;
         void'(order_ok(kvl_pkg::KIND_WORD));
         append_char(kvl_pkg::KIND_WORD, c);
      end
   endfunction

   function automatic void lex_byte(logic [7:0] c);
      step_results.delete();
      case (lx_mode)
         kvl_pkg::MODE_BLANK: blank_step(c);
         kvl_pkg::MODE_COMMENT: begin
            if (c == kvl_pkg::CH_NUL)
               close_text();
            else if (c == kvl_pkg::CH_LF)
               lx_mode = kvl_pkg::MODE_BLANK;
         end
         kvl_pkg::MODE_WORD: begin
            if (separator(c) || c == kvl_pkg::CH_EQUAL || c == kvl_pkg::CH_SEMI ||
                c == kvl_pkg::CH_NUL) begin
               if (lex_err == kvl_pkg::ST_OK)
                  emit(kvl_pkg::KIND_WORD, 1'b0, 8'h00, 1'b1, kvl_pkg::ST_OK);
               tok_len = 8'd0;
               lx_mode = kvl_pkg::MODE_BLANK;
               blank_step(c);
            end else begin
               append_char(kvl_pkg::KIND_WORD, c);
            end
         end
         default: begin
            if (c == kvl_pkg::CH_NUL) begin
               close_text();
            end else if ((!in_single_quote && c == kvl_pkg::CH_DQUOT) ||
                         (in_single_quote && c == kvl_pkg::CH_SQUOT)) begin
               if (lex_err == kvl_pkg::ST_OK)
                  emit(kvl_pkg::KIND_STRING, 1'b0, 8'h00, 1'b1, kvl_pkg::ST_OK);
               tok_len = 8'd0;
               lx_mode = kvl_pkg::MODE_BLANK;
            end else begin
               append_char(kvl_pkg::KIND_STRING, c);
            end
         end
      endcase
      if (step_results.size() > 0)
         step_results[step_results.size() - 1].last = 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] c, input logic [1:0] n_typed = 2'd0,
                            input kvl_pkg::result_type r0 = NO_RES,
                            input kvl_pkg::result_type r1 = NO_RES);
      if (!calm) begin
         while ($urandom_range(0, 99) < 23) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_in_char <= c;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      bytes_sent++;
      lex_byte(c);
      if (n_typed == 2'd0) begin
         foreach (step_results[k])
            pending_tokens.push_back(step_results[k]);
      end else begin
         pending_tokens.push_back(r0);
         if (n_typed == 2'd2)
            pending_tokens.push_back(r1);
      end
   endtask

   // random text generation
   function automatic logic [7:0] word_char(bit lead);
      logic [7:0] c;
      do begin
         case ($urandom_range(0, 7))
            0:       c = 8'($urandom_range(1, 255));
            1:       c = SPECIAL_CHARS[$urandom_range(6, 9)];
            default: c = 8'($urandom_range(8'h61, 8'h7A));
         endcase
      end while (separator(c) || c == kvl_pkg::CH_EQUAL || c == kvl_pkg::CH_SEMI ||
                 (lead && (c == kvl_pkg::CH_HASH || c == kvl_pkg::CH_DQUOT ||
                           c == kvl_pkg::CH_SQUOT)));
      return c;
   endfunction

   function automatic void add_word(int len);
      for (int i = 0; i < len; i++)
         text_q.push_back(word_char(i == 0));
   endfunction

   function automatic void add_string(int len, bit closed);
      logic [7:0] quote;
      logic [7:0] c;
      quote = $urandom_range(0, 1) ? kvl_pkg::CH_SQUOT : kvl_pkg::CH_DQUOT;
      text_q.push_back(quote);
      for (int i = 0; i < len; i++) begin
         do begin
            if ($urandom_range(0, 3) == 0)
               c = 8'($urandom_range(1, 255));
            else
               c = SPECIAL_CHARS[$urandom_range(0, 9)];
         end while (c == quote);
         text_q.push_back(c);
      end
      if (closed)
         text_q.push_back(quote);
   endfunction

   function automatic void add_gap();
      logic [7:0] c;
      int n;
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++)
         text_q.push_back(SPECIAL_CHARS[$urandom_range(0, 3)]);
      if ($urandom_range(0, 7) == 0) begin
         text_q.push_back(kvl_pkg::CH_HASH);
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) begin
            do c = 8'($urandom_range(1, 255)); while (c == kvl_pkg::CH_LF);
            text_q.push_back(c);
         end
         text_q.push_back(kvl_pkg::CH_LF);
      end
   endfunction

   // mostly well-formed statements; some noise, dropped or doubled tokens, cut-off endings
   function automatic void build_text(int idx);
      int shape;
      int n_stmt;
      int skip;
      shape = $urandom_range(0, 99);
      n_stmt = $urandom_range(1, 4);
      if (idx == 2)
         shape = 50;
      text_q.delete();
      if (shape < 8) begin
         repeat ($urandom_range(1, 20)) begin
            if ($urandom_range(0, 2) == 0)
               text_q.push_back(8'($urandom_range(0, 255)));
            else
               text_q.push_back(SPECIAL_CHARS[$urandom_range(0, 9)]);
         end
      end else begin
         for (int s = 0; s < n_stmt; s++) begin
            skip = (shape < 22) ? $urandom_range(0, 4) : 5;
            add_gap();
            if (skip != 0)
               add_word($urandom_range(1, 6));
            add_gap();
            if (skip != 1)
               text_q.push_back(kvl_pkg::CH_EQUAL);
            if (skip == 4)
               text_q.push_back(kvl_pkg::CH_EQUAL);
            add_gap();
            if (skip != 2) begin
               if (idx == 2 && s == 0)
                  add_string(256, 1'b1);
               else if ($urandom_range(0, 1))
                  add_string($urandom_range(0, 5), 1'b1);
               else
                  add_word($urandom_range(1, 6));
            end
            add_gap();
            if (skip != 3)
               text_q.push_back(kvl_pkg::CH_SEMI);
         end
         if (shape >= 88) begin
            add_word($urandom_range(1, 4));
            if ($urandom_range(0, 1)) begin
               text_q.push_back(kvl_pkg::CH_EQUAL);
               if ($urandom_range(0, 1))
                  add_string($urandom_range(0, 4), 1'b0);
            end
         end
      end
      text_q.push_back(kvl_pkg::CH_NUL);
   endfunction

   // result side
   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         flag_error($sformatf("result %0d %s: got %0d, expected %0d",
                              checked_count, name, got, want));
   endtask

   task automatic check_result();
      kvl_pkg::result_type got;
      kvl_pkg::result_type want;
      got = '{rsp_out_kind, rsp_has_char, rsp_out_char, rsp_token_done, rsp_status,
              rsp_last_of_run};
      if (pending_tokens.size() == 0) begin
         flag_error($sformatf("unexpected result: kind %0d char %02h status %0d",
                              got.kind, got.ch, got.status));
         return;
      end
      want = pending_tokens.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("has_char", got.has_char, want.has_char);
      check_field("out_char", got.ch, want.ch);
      check_field("token_done", got.token_done, want.token_done);
      check_field("status", got.status, want.status);
      check_field("last_of_run", got.last, want.last);
      checked_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_result();
      if (hold_asked != hold_given) begin
         hold_given = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 23);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int text_idx;
      int drain;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_STEPS[i])
         send_byte(DIRECTED_STEPS[i].ch, DIRECTED_STEPS[i].n_typed,
                   DIRECTED_STEPS[i].r0, DIRECTED_STEPS[i].r1);

      text_idx = 0;
      while (bytes_sent < RANDOM_TARGET) begin
         if (text_idx == 1) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_tokens.size() != 0);
         end
         if (text_idx == 3)
            hold_asked++;
         calm = (text_idx >= 4 && text_idx <= 7);
         build_text(text_idx);
         foreach (text_q[k])
            send_byte(text_q[k]);
         text_idx++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (pending_tokens.size() != 0 && drain < DRAIN_LIMIT);
      if (pending_tokens.size() != 0)
         flag_error($sformatf("%0d expected results never arrived", pending_tokens.size()));
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
rtl/kvl_pkg.sv
rtl/kvl_front.sv
rtl/kvl_fifo.sv
rtl/kvl_back.sv
rtl/key_value_config_lexer.sv
rtl/kvl_checker.sv
bench/key_value_config_lexer_test.sv
